FILE: rtl/gffra_pkg.sv
`timescale 1ns / 1ps

package gffra_pkg;

  localparam int GRID_ROWS = 16;
  localparam int GRID_COLS = 16;
  localparam int ID_BITS   = 16;

  localparam int CELLS  = GRID_ROWS * GRID_COLS;
  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int CELL_W = ROW_W + COL_W;

  // width of the size registers and rectangle fields
  localparam int DIM_W = 5;
  localparam int SUM_W = DIM_W + 1;

  localparam logic [ID_BITS-1:0] ID_MAX = '1;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_ADD_CHK = 5'b00010,
    ST_ADD_WR  = 5'b00100,
    ST_SCAN    = 5'b01000,
    ST_PUT     = 5'b10000
  } state_t;

  // register index, taken from paddr bit 2
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // columns [c, c+w) of one grid row
  function automatic logic [GRID_COLS-1:0] span_mask(logic [DIM_W-1:0] w,
                                                     logic [DIM_W-1:0] c);
    logic [GRID_COLS-1:0] m;
    for (int i = 0; i < GRID_COLS; i++) begin
      m[i] = (i >= int'(c)) && (i < int'(c) + int'(w));
    end
    return m;
  endfunction

endpackage

FILE: rtl/grid_first_fit_rect_allocator_core.sv
`timescale 1ns / 1ps

// Channel  Handshake                 Beat contents
// -------  ------------------------  ---------------------------------------
// in       in_valid / in_ready       cmd, rect_height, rect_width, item_id
// out      out_valid / out_ready     ok, assigned_id, row, col
// cfg      psel/penable/pwrite/pready rows_in_use @0x0, cols_in_use @0x4
//
// One request at a time; in_ready is high only while the sequencer idles.
// Add: accept, then one occupancy row check per cycle (up to h per anchor),
//   h*w owner writes, then the output load; a failed precheck goes straight to the output load.
// Remove reads all 256 cells; find stops at the first hit.
// Reset (sync, rst high) empties the grid at once via the occupancy flops.
// A stalled out channel only stalls the sequencer when a second result is ready.
module grid_first_fit_rect_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [gffra_pkg::DIM_W-1:0]   rect_height,
  input  logic [gffra_pkg::DIM_W-1:0]   rect_width,
  input  logic [gffra_pkg::ID_BITS-1:0] item_id,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic [gffra_pkg::ID_BITS-1:0] assigned_id,
  output logic [3:0]                    row,
  output logic [3:0]                    col,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import gffra_pkg::*;

  state_t st;

  logic [DIM_W-1:0] rows_in_use, cols_in_use;
  logic [DIM_W-1:0] nr, nc;

  // request latch
  logic [DIM_W-1:0]   h, w;
  logic [ID_BITS-1:0] id_key;
  logic               find_mode;
  logic [ID_BITS-1:0] last_id;

  // add walk
  logic [ROW_W-1:0] ar, aa, wa;
  logic [COL_W-1:0] ac, wb;
  logic [ROW_W-1:0] chk_row;
  logic             blocked;
  logic             add_last_row;
  logic [ROW_W-1:0] wr_row;
  logic [COL_W-1:0] wr_col;

  // scan pipeline
  logic [CELL_W:0]   cnt;
  logic              issuing;
  logic              p_vld;
  logic [CELL_W-1:0] p_addr;
  logic              hit;

  // occupancy flops: set means the cell holds a nonzero owner
  logic [GRID_COLS-1:0] occ [GRID_ROWS];

  // owner memory
  logic [ID_BITS-1:0] mem [CELLS];
  logic [ID_BITS-1:0] mem_q;
  logic               mem_we;

  // pending result
  logic               res_ok;
  logic [ID_BITS-1:0] res_id;
  logic [3:0]         res_row, res_col;

  logic accept;
  logic pre_fail;
  logic cfg_wr;

  // ---------------- config port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= DIM_W'(GRID_ROWS);
      cols_in_use <= DIM_W'(GRID_COLS);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_COLS) begin
        cols_in_use <= pwdata[DIM_W-1:0];
      end else begin
        rows_in_use <= pwdata[DIM_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_COLS) begin
      prdata = 32'(cols_in_use);
    end else begin
      prdata = 32'(rows_in_use);
    end
  end

  // usable area, clamped to the physical grid
  assign nr = (rows_in_use > DIM_W'(GRID_ROWS)) ? DIM_W'(GRID_ROWS) : rows_in_use;
  assign nc = (cols_in_use > DIM_W'(GRID_COLS)) ? DIM_W'(GRID_COLS) : cols_in_use;

  // ---------------- request side ----------------
  assign in_ready = (st == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign pre_fail = (rect_height == '0) || (rect_width == '0) ||
                    (rect_height > nr) || (rect_width > nc) || (last_id == ID_MAX);

  // add: one row of the candidate rectangle per cycle
  assign chk_row      = ar + aa;
  assign blocked      = |(occ[chk_row] & span_mask(w, DIM_W'(ac)));
  assign add_last_row = ({1'b0, aa} + DIM_W'(1)) == h;

  assign wr_row = ar + wa;
  assign wr_col = ac + wb;
  assign mem_we = (st == ST_ADD_WR);

  // remove / find: one cell per cycle, compared in the cycle after its read
  assign issuing = !cnt[CELL_W];
  assign hit = p_vld && occ[p_addr[CELL_W-1:COL_W]][p_addr[COL_W-1:0]] &&
               (mem_q == id_key);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{wr_row, wr_col}] <= last_id;
    end
    mem_q <= mem[cnt[CELL_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GRID_ROWS; i++) begin
        occ[i] <= '0;
      end
    end else if (st == ST_ADD_WR) begin
      occ[wr_row][wr_col] <= 1'b1;
    end else if (st == ST_SCAN && !find_mode && hit) begin
      occ[p_addr[CELL_W-1:COL_W]][p_addr[COL_W-1:0]] <= 1'b0;
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      last_id   <= '0;
      p_vld     <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      // the output load in ST_PUT owns out_valid in that state
      if (out_ready && st != ST_PUT) begin
        out_valid <= 1'b0;
      end

      case (st)
        ST_IDLE: begin
          if (accept) begin
            h         <= rect_height;
            w         <= rect_width;
            id_key    <= item_id;
            find_mode <= (cmd == CMD_FIND);
            res_ok    <= 1'b0;
            res_id    <= '0;
            res_row   <= '0;
            res_col   <= '0;
            ar        <= '0;
            ac        <= '0;
            aa        <= '0;
            cnt       <= '0;
            p_vld     <= 1'b0;
            case (cmd)
              CMD_ADD: begin
                st <= pre_fail ? ST_PUT : ST_ADD_CHK;
              end
              CMD_REMOVE, CMD_FIND: begin
                st <= ST_SCAN;
              end
              default: begin
                st <= ST_PUT;
              end
            endcase
          end
        end

        ST_ADD_CHK: begin
          if (!blocked) begin
            if (add_last_row) begin
              last_id <= last_id + ID_BITS'(1);
              wa      <= '0;
              wb      <= '0;
              st      <= ST_ADD_WR;
            end else begin
              aa <= aa + ROW_W'(1);
            end
          end else begin
            aa <= '0;
            if ((SUM_W'(ac) + SUM_W'(1) + SUM_W'(w)) <= SUM_W'(nc)) begin
              ac <= ac + COL_W'(1);
            end else begin
              ac <= '0;
              if ((SUM_W'(ar) + SUM_W'(1) + SUM_W'(h)) <= SUM_W'(nr)) begin
                ar <= ar + ROW_W'(1);
              end else begin
                st <= ST_PUT;   // no room anywhere
              end
            end
          end
        end

        ST_ADD_WR: begin
          if (({1'b0, wb} + DIM_W'(1)) == w) begin
            wb <= '0;
            if (({1'b0, wa} + DIM_W'(1)) == h) begin
              res_ok  <= 1'b1;
              res_id  <= last_id;
              res_row <= 4'(ar);
              res_col <= 4'(ac);
              st      <= ST_PUT;
            end else begin
              wa <= wa + ROW_W'(1);
            end
          end else begin
            wb <= wb + COL_W'(1);
          end
        end

        ST_SCAN: begin
          p_vld  <= issuing;
          p_addr <= cnt[CELL_W-1:0];
          if (issuing) begin
            cnt <= cnt + (CELL_W+1)'(1);
          end
          if (hit) begin
            res_ok <= 1'b1;
            if (find_mode) begin
              res_row <= 4'(p_addr[CELL_W-1:COL_W]);
              res_col <= 4'(p_addr[COL_W-1:0]);
              st      <= ST_PUT;
            end
          end
          if (!issuing && !p_vld) begin
            st <= ST_PUT;
          end
        end

        ST_PUT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            ok          <= res_ok;
            assigned_id <= res_id;
            row         <= res_row;
            col         <= res_col;
            st          <= ST_IDLE;
          end
        end

        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------- checks ----------------
  // placement never lands on an occupied cell
  a_wr_free: assert property (@(posedge clk) disable iff (rst)
    (st == ST_ADD_WR) |-> !occ[wr_row][wr_col])
    else $error("add writes an occupied cell");

  // a placed rectangle takes exactly the next id
  a_id_step: assert property (@(posedge clk) disable iff (rst)
    (st == ST_ADD_CHK && !blocked && add_last_row) |=>
      (last_id == $past(last_id) + ID_BITS'(1)))
    else $error("id counter did not advance by one");

  // an id is only reported with success
  a_id_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && assigned_id != '0) |-> ok)
    else $error("assigned id on a failed result");

endmodule
